// ===== rtl/uss_pkg.sv =====
package uss_pkg;

    // Payload of one input transaction.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // Payload of one output transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_has_byte;
        logic       out_last;
    } t_out_item;

    // Widest decoded code point comes from a four-byte sequence.
    localparam int unsigned CP_W     = 21;
    // A decoded character and a space in front of it never exceed four bytes.
    localparam int unsigned PUT_MAX  = 4;
    localparam int unsigned PUT_LENW = $clog2(PUT_MAX + 1);
    localparam int unsigned IDX_W    = $clog2(PUT_MAX);

    typedef logic [CP_W-1:0] t_cp;

    typedef struct packed {
        logic [PUT_MAX-1:0][7:0] bytes;
        logic [PUT_LENW-1:0]     len;
        logic                    pend;
        logic                    seen;
    } t_put;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam t_cp        CP_NL     = 21'h00000A;
    localparam t_cp        CP_TAB    = 21'h000009;
    localparam t_cp        CP_SPACE  = 21'h000020;
    localparam t_cp        CP_STAR   = 21'h00002A;
    localparam t_cp        CP_DQUOTE = 21'h000022;
    localparam t_cp        CP_HASH   = 21'h000023;
    localparam t_cp        CP_COMMA  = 21'h00002C;
    localparam t_cp        CP_DOT    = 21'h00002E;
    localparam t_cp        CP_SEMI   = 21'h00003B;
    localparam t_cp        CP_COLON  = 21'h00003A;
    localparam t_cp        CP_EXCL   = 21'h000021;
    localparam t_cp        CP_QUEST  = 21'h00003F;
    localparam t_cp        CP_APOS   = 21'h000027;
    localparam t_cp        CP_DASH   = 21'h00002D;
    localparam t_cp        CP_PCT    = 21'h000025;
    localparam t_cp        CP_LAT_LO = 21'h0000C0;
    localparam t_cp        CP_LAT_HI = 21'h00024F;
    localparam t_cp        CP_ELLIP  = 21'h002026;
    localparam t_cp        CP_ONE_HI = 21'h000080;
    localparam t_cp        CP_TWO_HI = 21'h000800;

    // Filters one code point, tracks the space state and re-encodes it.
    function automatic t_put f_put(input logic vld, input t_cp cp,
                                   input logic pend, input logic seen);
        t_put                r;
        logic                is_sp;
        logic                is_ch;
        logic [2:0][7:0]     enc;
        logic [PUT_LENW-1:0] enc_len;
        r.bytes = '0;
        r.len   = '0;
        r.pend  = pend;
        r.seen  = seen;
        enc     = '0;
        enc_len = '0;
        is_sp = vld && (cp == CP_SPACE || cp == CP_NL || cp == CP_TAB ||
                        cp == CP_STAR || cp == CP_DQUOTE || cp == CP_HASH);
        is_ch = vld && !is_sp &&
                ((cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h41 && cp <= 21'h5A) ||
                 (cp >= 21'h30 && cp <= 21'h39) ||
                 (cp >= CP_LAT_LO && cp <= CP_LAT_HI) ||
                 cp == CP_COMMA || cp == CP_DOT || cp == CP_SEMI || cp == CP_COLON ||
                 cp == CP_EXCL || cp == CP_QUEST || cp == CP_APOS || cp == CP_DASH ||
                 cp == CP_PCT || cp == CP_ELLIP);
        if (cp < CP_ONE_HI) begin
            enc[0]  = cp[7:0];
            enc_len = PUT_LENW'(1);
        end else if (cp < CP_TWO_HI) begin
            enc[0]  = {3'b110, cp[10:6]};
            enc[1]  = {2'b10, cp[5:0]};
            enc_len = PUT_LENW'(2);
        end else begin
            enc[0]  = {4'b1110, cp[15:12]};
            enc[1]  = {2'b10, cp[11:6]};
            enc[2]  = {2'b10, cp[5:0]};
            enc_len = PUT_LENW'(3);
        end
        if (is_sp) begin
            r.pend = pend | seen;
        end else if (is_ch) begin
            if (pend) begin
                r.bytes = {enc, CH_SPACE};
                r.len   = enc_len + PUT_LENW'(1);
            end else begin
                r.bytes = {8'h00, enc};
                r.len   = enc_len;
            end
            r.pend = 1'b0;
            r.seen = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/uss_stream_if.sv =====
interface uss_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/utf8_speech_text_sanitizer.sv =====
// Channel   Direction  Payload                              Accepted when
// i_in      sink       in_byte, in_last                     valid & ready
// o_out     source     out_byte, out_has_byte, out_last     valid & ready
//
// One input byte is taken per cycle while the output is ready and each byte yields
// at most one output byte. An accepted input byte passes through the input register
// and then the result register, from which its output transactions are sent.
// An item that yields n output transactions (at most four) holds the result register
// until all n have left, and the input register stalls behind it meanwhile.
// Reset is synchronous and active low; it clears the decoder and handshake state.
module utf8_speech_text_sanitizer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    uss_stream_if.sink   i_in,
    uss_stream_if.source o_out
);
    import uss_pkg::*;

    // Input register: holds one accepted byte until the result register is free.
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Decoder state. The held bytes are payload and are only read below r_hc.
    logic [7:0] r_held [3];
    logic [1:0] r_hc;
    logic [1:0] r_need;
    logic       r_pend;
    logic       r_seen;

    // Result register: one item's output bytes, drained one per cycle while o_out is ready.
    logic                    r_pk_vld;
    logic [PUT_MAX-1:0][7:0] r_pk_bytes;
    logic [IDX_W-1:0]        r_pk_idx;
    logic [IDX_W-1:0]        r_pk_lst;
    logic                    r_pk_bare;
    logic                    r_pk_last;

    logic out_pop;
    logic pk_done;
    logic pk_free;
    logic adv;
    logic in_take;

    // Handshake. The result register frees up in the cycle its final byte leaves,
    // so a stream of one-byte items flows without a bubble.
    assign out_pop    = r_pk_vld && o_out.ready;
    assign pk_done    = out_pop && (r_pk_idx == r_pk_lst);
    assign pk_free    = !r_pk_vld || pk_done;
    assign adv        = r_in_vld && pk_free;
    assign i_in.ready = !r_in_vld || adv;
    assign in_take    = i_in.valid && i_in.ready;

    assign o_out.valid             = r_pk_vld;
    assign o_out.data.out_byte     = r_pk_bare ? 8'h00 : r_pk_bytes[r_pk_idx];
    assign o_out.data.out_has_byte = !r_pk_bare;
    assign o_out.data.out_last     = r_pk_last && (r_pk_idx == r_pk_lst);

    // Byte classification.
    logic is_asc, is_l2, is_l3, is_l4;
    logic h1_asc, h1_l2;
    assign is_asc = !r_in_byte[7];
    assign is_l2  = r_in_byte[7:5] == 3'b110;
    assign is_l3  = r_in_byte[7:4] == 4'b1110;
    assign is_l4  = r_in_byte[7:3] == 5'b11110;
    assign h1_asc = !r_held[1][7];
    assign h1_l2  = r_held[1][7:5] == 3'b110;

    // Sequence tracking. At most two code points come out of one byte: two only
    // when the text ends inside a four-byte sequence and the continuation byte
    // held after the dropped lead byte and the final byte are both ASCII.
    logic       a_vld, b_vld;
    t_cp        a_cp, b_cp;
    logic [1:0] n_hc, n_need;
    logic       wr_en;
    logic [1:0] wr_idx;

    always_comb begin
        a_vld  = 1'b0;
        b_vld  = 1'b0;
        a_cp   = t_cp'(r_in_byte);
        b_cp   = t_cp'(r_in_byte);
        n_hc   = r_hc;
        n_need = r_need;
        wr_en  = 1'b0;
        wr_idx = r_hc;
        if (r_hc == 2'd0) begin
            if (is_asc) begin
                a_vld = 1'b1;
            end else if (!r_in_last && (is_l2 || is_l3 || is_l4)) begin
                wr_en  = 1'b1;
                wr_idx = 2'd0;
                n_hc   = 2'd1;
                n_need = is_l2 ? 2'd1 : (is_l3 ? 2'd2 : 2'd3);
            end
        end else if (r_need <= 2'd1) begin
            // Final continuation: assemble the code point from the held bytes.
            a_vld = 1'b1;
            case (r_hc)
                2'd1:    a_cp = t_cp'({r_held[0][4:0], r_in_byte[5:0]});
                2'd2:    a_cp = t_cp'({r_held[0][3:0], r_held[1][5:0], r_in_byte[5:0]});
                default: a_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0],
                                 r_in_byte[5:0]};
            endcase
            n_hc   = 2'd0;
            n_need = 2'd0;
        end else if (!r_in_last) begin
            wr_en  = 1'b1;
            n_hc   = r_hc + 2'd1;
            n_need = r_need - 2'd1;
        end else begin
            // Text ends inside a sequence: the lead byte goes, the rest is decoded
            // again as a short run.
            if (r_hc == 2'd1) begin
                a_vld = is_asc;
            end else if (h1_asc) begin
                a_vld = 1'b1;
                a_cp  = t_cp'(r_held[1]);
                b_vld = is_asc;
            end else if (h1_l2) begin
                a_vld = 1'b1;
                a_cp  = t_cp'({r_held[1][4:0], r_in_byte[5:0]});
            end else begin
                a_vld = is_asc;
            end
        end
        if (r_in_last) begin
            n_hc   = 2'd0;
            n_need = 2'd0;
        end
    end

    // Filtering, space handling and re-encoding, then the two byte lists are joined.
    t_put                    pa, pb;
    logic [PUT_MAX-1:0][7:0] merged;
    logic [PUT_LENW-1:0]     total;
    logic [PUT_LENW-1:0]     sub;

    assign pa    = f_put(a_vld, a_cp, r_pend, r_seen);
    assign pb    = f_put(b_vld, b_cp, pa.pend, pa.seen);
    assign total = pa.len + pb.len;

    always_comb begin
        merged = '0;
        sub    = '0;
        for (int i = 0; i < PUT_MAX; i++) begin
            sub = PUT_LENW'(i) - pa.len;
            if (PUT_LENW'(i) < pa.len) begin
                merged[i] = pa.bytes[i];
            end else begin
                merged[i] = pb.bytes[sub[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_hc     <= 2'd0;
            r_need   <= 2'd0;
            r_pend   <= 1'b0;
            r_seen   <= 1'b0;
            r_pk_vld <= 1'b0;
            r_pk_idx <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_hc     <= n_hc;
                r_need   <= n_need;
                r_pend   <= r_in_last ? 1'b0 : pb.pend;
                r_seen   <= r_in_last ? 1'b0 : pb.seen;
                r_pk_vld <= (total != '0) || r_in_last;
                r_pk_idx <= '0;
            end else if (pk_done) begin
                r_pk_vld <= 1'b0;
            end else if (out_pop) begin
                r_pk_idx <= r_pk_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.data.in_byte;
            r_in_last <= i_in.data.in_last;
        end
        if (adv && wr_en) begin
            r_held[wr_idx] <= r_in_byte;
        end
        if (adv) begin
            r_pk_bytes <= merged;
            r_pk_last  <= r_in_last;
            // An end of text that makes no byte sends one bare end marker.
            r_pk_bare  <= (total == '0);
            r_pk_lst   <= (total == '0) ? '0 : IDX_W'(total - PUT_LENW'(1));
        end
    end

    // The drain index never runs past the final byte of the held result.
    a_pk_idx : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pk_vld |-> (r_pk_idx <= r_pk_lst))
        else $error("result index past final byte");

    // A bare transaction is only ever the end marker.
    a_bare_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.out_has_byte) |-> o_out.data.out_last)
        else $error("bare transaction without end mark");

    // The end of a text leaves the decoder as after reset.
    a_text_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (r_hc == 2'd0 && r_need == 2'd0 && !r_pend && !r_seen))
        else $error("state not cleared at end of text");

    // While bytes are held, at least one continuation is still awaited.
    a_need : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hc != 2'd0) |-> (r_need != 2'd0))
        else $error("held bytes with nothing awaited");

endmodule
